/* hw/rtl/spbp_pkg.sv */
// Shared types and helpers for the sphere broad-phase pair finder.
package spbp_pkg;

    // One stored body: center and bounding radius (largest size component).
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] radius;
        logic               stat;
    } body_t;

    // Operation codes on the input channel.
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    function automatic logic signed [31:0] max3(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic signed [31:0] c
    );
        logic signed [31:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

/* hw/rtl/spbp_cell.sv */
// One body slot of the rotating body ring.
module spbp_cell
(
    input  logic          clk,
    input  logic          shift,
    input  spbp_pkg::body_t rec_in,
    output spbp_pkg::body_t rec_out
);
    import spbp_pkg::*;

    body_t rec_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            rec_reg <= rec_in;
        end
    end

    assign rec_out = rec_reg;

endmodule

/* hw/rtl/spbp_pair_test.sv */
// Three-stage sphere overlap test: |d|^2 <= (ra+rb)^2.
module spbp_pair_test #(
    parameter int IW = 6
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [IW-1:0]   in_idx,
    input  spbp_pkg::body_t rec_a,
    input  spbp_pkg::body_t rec_b,
    output logic            hit_vld,
    output logic [IW-1:0]   hit_idx,
    output logic            busy
);
    import spbp_pkg::*;

    function automatic logic [32:0] mag33(input logic signed [32:0] d);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    logic            v1_reg, v2_reg, v3_reg;
    logic [IW-1:0]   i1_reg, i2_reg, i3_reg;
    logic [32:0]     mx_reg, my_reg, mz_reg, ms_reg;
    logic [65:0]     px_reg, py_reg, pz_reg, lim_reg;
    logic [66:0]     d2_reg;
    logic [65:0]     lim3_reg;

    logic signed [32:0] dx, dy, dz, rs;

    assign dx = {rec_a.pos_x[31], rec_a.pos_x} - {rec_b.pos_x[31], rec_b.pos_x};
    assign dy = {rec_a.pos_y[31], rec_a.pos_y} - {rec_b.pos_y[31], rec_b.pos_y};
    assign dz = {rec_a.pos_z[31], rec_a.pos_z} - {rec_b.pos_z[31], rec_b.pos_z};
    assign rs = {rec_a.radius[31], rec_a.radius} + {rec_b.radius[31], rec_b.radius};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: magnitudes
            i1_reg   <= in_idx;
            mx_reg   <= mag33(dx);
            my_reg   <= mag33(dy);
            mz_reg   <= mag33(dz);
            ms_reg   <= mag33(rs);
            // stage 2: squares
            i2_reg   <= i1_reg;
            px_reg   <= mx_reg * mx_reg;
            py_reg   <= my_reg * my_reg;
            pz_reg   <= mz_reg * mz_reg;
            lim_reg  <= ms_reg * ms_reg;
            // stage 3: distance sum
            i3_reg   <= i2_reg;
            d2_reg   <= 67'(px_reg) + 67'(py_reg) + 67'(pz_reg);
            lim3_reg <= lim_reg;
        end
    end

    assign hit_vld = v3_reg && (d2_reg <= {1'b0, lim3_reg});
    assign hit_idx = i3_reg;
    assign busy    = v1_reg | v2_reg | v3_reg;

endmodule

/* hw/rtl/sphere_broad_phase_pairs_top.sv */
// Top level of the all-pairs bounding-sphere broad-phase pair finder.
// Bodies live in a ring of MAX_BODIES cells that rotates by one slot on every
// cycle the block is not stalled by the output; a counter tracks which body
// index sits at the ring head. A store beat waits until its index reaches the
// head and writes the record back in place of it. A query beat waits for body
// i at the head, then the bodies i+1 .. count-1 leave the head one per cycle
// while not stalled, into a three-stage overlap test (subtract and magnitude,
// square, sum), skipping static-static pairs, and the query ends once that
// test has drained after the last body. A query with no candidates goes
// straight to its final result. Results come out at most one per cycle; one
// hit is held back so the final result of a query can carry last. Radii are
// taken as the largest size component when a body is stored. A query reading
// an entry never stored gives arbitrary pairs. The input is taken only
// between items.
module sphere_broad_phase_pairs_top #(
    parameter int MAX_BODIES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [5:0]         index,
    input  logic [6:0]         body_count,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] size_x,
    input  logic signed [31:0] size_y,
    input  logic signed [31:0] size_z,
    input  logic               is_static,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         body_a,
    output logic [5:0]         body_b,
    output logic               hit,
    output logic               last
);
    import spbp_pkg::*;

    localparam int HW = $clog2(MAX_BODIES);
    localparam int CW = ((HW > 7) ? HW : 7) + 1;   // compare width

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK_STORE,
        ST_SEEK_QUERY,
        ST_FEED,
        ST_DRAIN
    } state_t;

    state_t          state_reg;
    logic [HW-1:0]   head_reg;      // index of the body in the head cell
    logic [5:0]      tgt_reg;       // index being stored or queried
    logic [CW-1:0]   cnt_reg;       // saturated body count
    body_t           new_reg;       // record to store
    body_t           a_reg;         // queried body
    logic            pend_reg;      // a hit is held back
    logic [HW-1:0]   pend_b_reg;
    logic            out_valid_reg;
    logic [5:0]      body_a_reg, body_b_reg;
    logic            hit_reg, last_reg;

    logic            en;
    logic            accept;
    logic            emit;
    logic            at_tgt;
    logic            wr_head;
    logic [CW-1:0]   idx_ext, cnt_in, head_ext;
    logic [HW-1:0]   head_next;
    body_t           ring_in;
    body_t           ring_q [MAX_BODIES];
    body_t           head_rec;
    logic            pt_vld, pt_hit, pt_busy;
    logic [HW-1:0]   pt_idx;

    // Ring and pair test freeze while a result waits to be taken.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // A new result beat is loaded this cycle.
    assign emit     = en && ((state_reg == ST_DRAIN && !pt_busy) || (pt_hit && pend_reg));

    assign idx_ext  = CW'(index);
    assign cnt_in   = (CW'(body_count) > CW'(MAX_BODIES)) ? CW'(MAX_BODIES)
                                                          : CW'(body_count);
    assign head_ext = CW'(head_reg);
    assign at_tgt   = (head_ext == CW'(tgt_reg));
    assign head_rec = ring_q[MAX_BODIES-1];
    assign wr_head  = (state_reg == ST_SEEK_STORE) && at_tgt;
    assign ring_in  = wr_head ? new_reg : head_rec;
    assign head_next = (head_reg == HW'(MAX_BODIES - 1)) ? '0 : head_reg + 1'b1;

    // Ring of body cells; cell 0 is fed from the head (or a new record).
    genvar k;
    generate
        for (k = 0; k < MAX_BODIES; k++)
        begin : g_ring
            if (k == 0)
            begin : g_first
                spbp_cell u_cell (
                    .clk     (clk),
                    .shift   (en),
                    .rec_in  (ring_in),
                    .rec_out (ring_q[k])
                );
            end
            else
            begin : g_rest
                spbp_cell u_cell (
                    .clk     (clk),
                    .shift   (en),
                    .rec_in  (ring_q[k-1]),
                    .rec_out (ring_q[k])
                );
            end
        end
    endgenerate

    // Candidate issue: skip static-static pairs.
    assign pt_vld = (state_reg == ST_FEED) && !(a_reg.stat && head_rec.stat);

    spbp_pair_test #(
        .IW (HW)
    ) u_test (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (pt_vld),
        .in_idx  (head_reg),
        .rec_a   (a_reg),
        .rec_b   (head_rec),
        .hit_vld (pt_hit),
        .hit_idx (pt_idx),
        .busy    (pt_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tgt_reg       <= '0;
            cnt_reg       <= '0;
            new_reg       <= '0;
            a_reg         <= '0;
            pend_reg      <= 1'b0;
            pend_b_reg    <= '0;
            out_valid_reg <= 1'b0;
            body_a_reg    <= '0;
            body_b_reg    <= '0;
            hit_reg       <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                tgt_reg       <= index;
                cnt_reg       <= cnt_in;
                new_reg.pos_x <= pos_x;
                new_reg.pos_y <= pos_y;
                new_reg.pos_z <= pos_z;
                new_reg.radius <= max3(size_x, size_y, size_z);
                new_reg.stat  <= is_static;
                pend_reg      <= 1'b0;
                if (op == OP_STORE)
                begin
                    if (idx_ext < CW'(MAX_BODIES))
                    begin
                        state_reg <= ST_SEEK_STORE;
                    end
                end
                else if (idx_ext + 1'b1 >= cnt_in)
                begin
                    state_reg <= ST_DRAIN;      // no candidates
                end
                else
                begin
                    state_reg <= ST_SEEK_QUERY;
                end
            end

            if (en)
            begin
                head_reg <= head_next;

                unique case (state_reg)
                    ST_IDLE:
                    begin
                    end
                    ST_SEEK_STORE:
                    begin
                        if (at_tgt)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_SEEK_QUERY:
                    begin
                        if (at_tgt)
                        begin
                            a_reg     <= head_rec;
                            state_reg <= ST_FEED;
                        end
                    end
                    ST_FEED:
                    begin
                        if (head_ext == cnt_reg - 1'b1)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                    ST_DRAIN:
                    begin
                        if (!pt_busy)
                        begin
                            out_valid_reg <= 1'b1;
                            body_a_reg    <= tgt_reg;
                            body_b_reg    <= pend_reg ? 6'(pend_b_reg) : 6'd0;
                            hit_reg       <= pend_reg;
                            last_reg      <= 1'b1;
                            pend_reg      <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase

                // A new hit releases the one held back.
                if (pt_hit)
                begin
                    if (pend_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        body_a_reg    <= tgt_reg;
                        body_b_reg    <= 6'(pend_b_reg);
                        hit_reg       <= 1'b1;
                        last_reg      <= 1'b0;
                    end
                    pend_reg   <= 1'b1;
                    pend_b_reg <= pt_idx;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign body_a    = body_a_reg;
    assign body_b    = body_b_reg;
    assign hit       = hit_reg;
    assign last      = last_reg;

    // A result without a pair always closes its query.
    a_nohit_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg |-> last_reg)
        else $error("no-hit result without last");

    // Overlap tests only run while a query is feeding or draining.
    a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        pt_busy |-> (state_reg == ST_FEED || state_reg == ST_DRAIN))
        else $error("overlap pipeline busy outside a query");

    // A held-back hit exists only inside a query.
    a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_FEED || state_reg == ST_DRAIN))
        else $error("pending hit outside a query");

    // The final beat of a query returns the block to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        en && state_reg == ST_DRAIN && !pt_busy |=> state_reg == ST_IDLE)
        else $error("query did not end after final beat");

endmodule

/* test/sphere_broad_phase_pairs_checker.sv */
// Checker for the sphere broad-phase pair finder: predicts pairs and compares results.
module sphere_broad_phase_pairs_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               op,
    input  logic [5:0]         index,
    input  logic [6:0]         body_count,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] size_x,
    input  logic signed [31:0] size_y,
    input  logic signed [31:0] size_z,
    input  logic               is_static,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [5:0]         body_a,
    input  logic [5:0]         body_b,
    input  logic               hit,
    input  logic               last,
    output int                 errors,
    output int                 pending
);
    import spbp_pkg::*;

    typedef struct {
        logic [5:0] a;
        logic [5:0] b;
        logic       hit;
        logic       last;
    } pair_t;

    body_t bodies [64];
    pair_t pair_q [$];

    initial errors = 0;
    assign pending = pair_q.size();

    function automatic logic [32:0] abs_diff(logic signed [31:0] p, logic signed [31:0] q);
        logic signed [32:0] d;
        d = p - q;
        return (d < 0) ? -d : d;
    endfunction

    function automatic logic signed [31:0] largest(logic signed [31:0] a,
                                                   logic signed [31:0] b,
                                                   logic signed [31:0] c);
        logic signed [31:0] m;
        m = (a > b) ? a : b;
        if (c > m)
            m = c;
        return m;
    endfunction

    // exact: 33-bit magnitudes, 66-bit squares, 68-bit sum
    function automatic logic spheres_overlap(int i, int j);
        logic [32:0]        dx;
        logic [32:0]        dy;
        logic [32:0]        dz;
        logic [67:0]        dist2;
        logic signed [32:0] rsum;
        logic [32:0]        rmag;
        logic [67:0]        reach2;
        dx = abs_diff(bodies[i].pos_x, bodies[j].pos_x);
        dy = abs_diff(bodies[i].pos_y, bodies[j].pos_y);
        dz = abs_diff(bodies[i].pos_z, bodies[j].pos_z);
        dist2 = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
        rsum = 33'($signed(bodies[i].radius)) + 33'($signed(bodies[j].radius));
        rmag = (rsum < 0) ? -rsum : rsum;
        reach2 = 68'(rmag) * 68'(rmag);
        return dist2 <= reach2;
    endfunction

    task automatic predict_pairs();
        int    count;
        int    n;
        pair_t p;
        if (op == OP_STORE)
        begin
            bodies[index].pos_x  = pos_x;
            bodies[index].pos_y  = pos_y;
            bodies[index].pos_z  = pos_z;
            bodies[index].radius = largest(size_x, size_y, size_z);
            bodies[index].stat   = is_static;
        end
        else
        begin
            count = (int'(body_count) > 64) ? 64 : int'(body_count);
            n = 0;
            for (int j = int'(index) + 1; j < count; j++)
            begin
                if (bodies[index].stat && bodies[j].stat)
                    continue;
                if (spheres_overlap(int'(index), j))
                begin
                    p.a = index;
                    p.b = j[5:0];
                    p.hit = 1'b1;
                    p.last = 1'b0;
                    pair_q.insert(pair_q.size(), p);
                    n++;
                end
            end
            if (n == 0)
            begin
                p.a = index;
                p.b = '0;
                p.hit = 1'b0;
                p.last = 1'b1;
                pair_q.insert(pair_q.size(), p);
            end
            else
                pair_q[pair_q.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin : p_check
        pair_t e;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_pairs();
            if (out_valid && out_ready)
            begin
                if (pair_q.size() == 0)
                begin
                    $error("unexpected result beat a=%0d b=%0d", body_a, body_b);
                    errors++;
                end
                else
                begin
                    e = pair_q.pop_front();
                    if (body_a !== e.a)
                    begin
                        $error("body_a expected %0d got %0d", e.a, body_a);
                        errors++;
                    end
                    if (body_b !== e.b)
                    begin
                        $error("body_b expected %0d got %0d", e.b, body_b);
                        errors++;
                    end
                    if (hit !== e.hit)
                    begin
                        $error("hit expected %0d got %0d", e.hit, hit);
                        errors++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last expected %0d got %0d", e.last, last);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

/* test/sphere_broad_phase_pairs_top_tb.sv */
// Testbench top for the sphere broad-phase pair finder: stimulus, pacing and verdict.
module sphere_broad_phase_pairs_top_tb;
    import spbp_pkg::*;

    localparam logic signed [31:0] ONE = 32'sh0001_0000;  // 1.0 in Q16.16

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               op;
    logic [5:0]         index;
    logic [6:0]         body_count;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic signed [31:0] size_z;
    logic               is_static;
    logic               out_valid;
    logic               out_ready;
    logic [5:0]         body_a;
    logic [5:0]         body_b;
    logic               hit;
    logic               last;
    int                 errors;
    int                 pending;

    // pacing knobs, percent of beats followed by a gap and of cycles with ready low
    int tx_idle;
    int rx_idle;
    int hold_left;       // long receiver stall, counted down below
    bit stored [64];     // entries written so far; queries never read others

    sphere_broad_phase_pairs_top uut (.*);

    sphere_broad_phase_pairs_checker chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random ready, or held low for a long stretch when asked.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle);
    end

    // One input beat; valid stays up until taken, then maybe a gap.
    task automatic send_beat(logic o, logic [5:0] ix, logic [6:0] cnt,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic signed [31:0] sx,
                             logic signed [31:0] sy, logic signed [31:0] sz,
                             logic st);
        in_valid   <= 1'b1;
        op         <= o;
        index      <= ix;
        body_count <= cnt;
        pos_x      <= px;
        pos_y      <= py;
        pos_z      <= pz;
        size_x     <= sx;
        size_y     <= sy;
        size_z     <= sz;
        is_static  <= st;
        do @(posedge clk); while (!in_ready);
        if (o == OP_STORE)
            stored[ix] = 1'b1;
        if ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic store_body(logic [5:0] ix, logic signed [31:0] px,
                              logic signed [31:0] py, logic signed [31:0] pz,
                              logic signed [31:0] sx, logic signed [31:0] sy,
                              logic signed [31:0] sz, logic st);
        send_beat(OP_STORE, ix, 7'($urandom), px, py, pz, sx, sy, sz, st);
    endtask

    task automatic query_pairs(logic [5:0] ix, logic [6:0] cnt);
        send_beat(OP_QUERY, ix, cnt, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, 1'($urandom));
    endtask

    // Mostly a small cluster so spheres really touch; sometimes full range.
    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(99) < 80)
            return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
        return $urandom;
    endfunction

    function automatic logic signed [31:0] rand_size();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(0, 2 * ONE);
        if (r < 88)
            return -$signed($urandom_range(0, 2 * ONE));
        return $urandom;
    endfunction

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < 64 && stored[n])
            n++;
        return n;
    endfunction

    // Query with a count that only reaches stored entries.
    task automatic random_query();
        logic [5:0] ix;
        logic [6:0] cnt;
        int         eff;
        int         pre;
        ix  = 6'($urandom);
        cnt = ($urandom_range(99) < 75) ? 7'($urandom_range(0, 64))
                                        : 7'($urandom_range(0, 127));
        pre = written_prefix();
        eff = (cnt > 64) ? 64 : int'(cnt);
        if (ix + 1 < eff && eff > pre)
            cnt = 7'(pre);
        query_pairs(ix, cnt);
    endtask

    task automatic random_items(int n, int hold_at);
        int pre;
        for (int k = 0; k < n; k++)
        begin
            if (k == hold_at)
                hold_left <= 400;    // block fills up while we keep offering
            pre = written_prefix();
            if ($urandom_range(99) < 35 || pre < 4)
            begin
                if (pre < 64 && $urandom_range(1))
                    store_body(6'(pre), rand_coord(), rand_coord(), rand_coord(),
                               rand_size(), rand_size(), rand_size(), 1'($urandom));
                else
                    store_body(6'($urandom), rand_coord(), rand_coord(), rand_coord(),
                               rand_size(), rand_size(), rand_size(), 1'($urandom));
            end
            else
                random_query();
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_STORE;
        index      = '0;
        body_count = '0;
        pos_x      = '0;
        pos_y      = '0;
        pos_z      = '0;
        size_x     = '0;
        size_y     = '0;
        size_z     = '0;
        is_static  = 1'b0;
        out_ready  = 1'b0;
        hold_left  = 0;
        tx_idle    = 10;
        rx_idle    = 45;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: touching at the exact boundary, far apart, static pair,
        // extreme coordinates, negative sizes
        store_body(0, 0, 0, 0, ONE, ONE / 2, ONE / 4, 1'b0);
        store_body(1, 3 * ONE / 2, 0, 0, ONE / 2, ONE / 4, 0, 1'b0);
        store_body(2, 100 * ONE, 0, 0, ONE, ONE, ONE, 1'b0);
        store_body(3, ONE / 2, 0, 0, ONE, 0, 0, 1'b1);
        store_body(4, ONE / 2, ONE / 2, 0, ONE, 0, 0, 1'b1);
        store_body(5, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                   32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
        store_body(6, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                   32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        store_body(7, 0, 0, 0, -3 * ONE, -2 * ONE, -5 * ONE, 1'b0);
        store_body(63, 32'sh7fff_ffff, 32'sh8000_0000, 0,
                   32'sh7fff_ffff, 0, 32'sh8000_0000, 1'b1);
        query_pairs(0, 8);
        query_pairs(1, 8);
        query_pairs(3, 5);
        query_pairs(5, 7);
        query_pairs(6, 8);
        query_pairs(7, 8);     // index is the last body: nothing to test
        query_pairs(2, 0);     // empty table
        query_pairs(4, 2);     // index past the count
        query_pairs(63, 127);  // count above the table, index at the top

        drain();               // sender waits for every pending pair
        random_items(160, 40);
        tx_idle = 45;
        rx_idle = 10;
        random_items(160, -1);
        drain();
        tx_idle = 0;
        rx_idle = 0;
        random_items(160, -1);

        drain();
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("sphere_broad_phase_pairs_top: match");
        else
            $display("sphere_broad_phase_pairs_top: mismatch");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("sphere_broad_phase_pairs_top: mismatch");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/spbp_pkg.sv
hw/rtl/spbp_cell.sv
hw/rtl/spbp_pair_test.sv
hw/rtl/sphere_broad_phase_pairs_top.sv
test/sphere_broad_phase_pairs_checker.sv
test/sphere_broad_phase_pairs_top_tb.sv
